// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/opi_pkg.sv =====
package opi_pkg;

	localparam int FRAC_BITS         = 16;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ANG_FRAC          = 24;
	localparam int ANG_SHIFT         = ANG_FRAC - FRAC_BITS;
	localparam int ITERS             = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
	localparam int CNT_W             = $clog2(ITERS);
	localparam int ATAN_IDX_W        = 5;

	localparam int STEP_W  = 32;
	localparam int DH_W    = 25;
	localparam int HACC_W  = 32;
	localparam int POSE_W  = 48;
	localparam int PH_W    = 27;
	localparam int HW      = 34;
	localparam int ANG_W   = 34;
	localparam int XY_W    = 34;
	localparam int PROD_W  = STEP_W + XY_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int ROUND_SH = 30;
	localparam int RX_W    = SUM_W - ROUND_SH;
	localparam int ASUM_W  = POSE_W + 1;

	localparam logic signed [XY_W-1:0] CORDIC_KINV = XY_W'(652032874);

	localparam logic signed [HW-1:0] FULL_H    = HW'(longint'(360) << FRAC_BITS);
	localparam logic signed [HW-1:0] HALF_H    = HW'(longint'(180) << FRAC_BITS);
	localparam logic signed [HW-1:0] QUARTER_H = HW'(longint'(90) << FRAC_BITS);

	typedef struct packed {
		logic                    start;
		logic                    neg;
		logic signed [ANG_W-1:0] z;
	} cordic_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [XY_W-1:0] cos_v;
		logic signed [XY_W-1:0] sin_v;
	} cordic_res_t;

	// arctan(2^-i) in degrees, 24 fraction bits
	function automatic logic signed [ANG_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:    v = ANG_W'(754974720);
			5'd1:    v = ANG_W'(445687602);
			5'd2:    v = ANG_W'(235489088);
			5'd3:    v = ANG_W'(119537938);
			5'd4:    v = ANG_W'(60000934);
			5'd5:    v = ANG_W'(30029717);
			5'd6:    v = ANG_W'(15018523);
			5'd7:    v = ANG_W'(7509720);
			5'd8:    v = ANG_W'(3754917);
			5'd9:    v = ANG_W'(1877466);
			5'd10:   v = ANG_W'(938734);
			5'd11:   v = ANG_W'(469367);
			5'd12:   v = ANG_W'(234684);
			5'd13:   v = ANG_W'(117342);
			5'd14:   v = ANG_W'(58671);
			5'd15:   v = ANG_W'(29335);
			5'd16:   v = ANG_W'(14668);
			5'd17:   v = ANG_W'(7334);
			5'd18:   v = ANG_W'(3667);
			5'd19:   v = ANG_W'(1833);
			5'd20:   v = ANG_W'(917);
			5'd21:   v = ANG_W'(458);
			5'd22:   v = ANG_W'(229);
			5'd23:   v = ANG_W'(115);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/opi_cordic.sv =====
module opi_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  opi_pkg::cordic_req_t req,
	output opi_pkg::cordic_res_t res
);
	import opi_pkg::*;

	localparam logic [CNT_W-1:0] LAST = CNT_W'(ITERS - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic                    neg_q;

	logic signed [XY_W-1:0]  xs, ys, nx, ny;
	logic signed [ANG_W-1:0] nz, at;

	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = atan_q24(ATAN_IDX_W'(cnt_q));
		if (z_q >= 0) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - at;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= CORDIC_KINV;
			y_q   <= '0;
			z_q   <= req.z;
			neg_q <= req.neg;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	// folded angles come back through a half turn
	assign res.done  = done_q;
	assign res.cos_v = neg_q ? -x_q : x_q;
	assign res.sin_v = neg_q ? -y_q : y_q;

endmodule

// ===== hdl/odometry_pose_integrator_top.sv =====
// a step goes through HEAD, MOD, HALF, FOLD, CORDIC, MUL0 to MUL4, RND and ACC to pose valid
// steps are taken one at a time; the next is accepted only back in S_IDLE
// most work is in the CORDIC rotation loop and the single shared multiplier (4 products)
// a pose waiting on a stalled output holds the next step back only for its final update
// arst_n clears the pose, heading and handshake state at once; no clearing sweep
module odometry_pose_integrator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_valid,
	output logic                               step_stall,
	input  logic signed [opi_pkg::STEP_W-1:0]  step_x,
	input  logic signed [opi_pkg::STEP_W-1:0]  step_y,
	input  logic signed [opi_pkg::DH_W-1:0]    step_heading,
	input  logic                               clear_pose,
	output logic                               pose_valid,
	input  logic                               pose_stall,
	output logic signed [opi_pkg::POSE_W-1:0]  pose_x,
	output logic signed [opi_pkg::POSE_W-1:0]  pose_y,
	output logic signed [opi_pkg::PH_W-1:0]    pose_heading
);
	import opi_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_HEAD   = 14'b00000000000010,
		S_MOD    = 14'b00000000000100,
		S_HALF   = 14'b00000000001000,
		S_FOLD   = 14'b00000000010000,
		S_CORDIC = 14'b00000000100000,
		S_MUL0   = 14'b00000001000000,
		S_MUL1   = 14'b00000010000000,
		S_MUL2   = 14'b00000100000000,
		S_MUL3   = 14'b00001000000000,
		S_MUL4   = 14'b00010000000000,
		S_RND    = 14'b00100000000000,
		S_ACC    = 14'b01000000000000,
		S_SPARE  = 14'b10000000000000
	} state_t;

	localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(longint'(1) << (ROUND_SH - 1));
	localparam logic signed [POSE_W-1:0] ACC_MAX = {1'b0, {(POSE_W-1){1'b1}}};
	localparam logic signed [POSE_W-1:0] ACC_MIN = {1'b1, {(POSE_W-1){1'b0}}};

	state_t state_q;

	logic signed [STEP_W-1:0] dx_q, dy_q;
	logic signed [DH_W-1:0]   dh_q;
	logic signed [POSE_W-1:0] acc_x_q, acc_y_q;
	logic signed [HACC_W-1:0] acc_h_q;
	logic signed [HW-1:0]     ang_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sx_q, sy_q;
	logic signed [RX_W-1:0]   rx_q, ry_q;
	logic                     pose_valid_q;
	logic signed [POSE_W-1:0] pose_x_q, pose_y_q;
	logic signed [PH_W-1:0]   pose_h_q;

	logic                     step_acc;
	logic                     load_ok;
	logic signed [HW-1:0]     h_sum, h_wrap, h_ext, fold_ang;
	logic                     fold_neg;
	logic signed [STEP_W-1:0] mul_a;
	logic signed [XY_W-1:0]   mul_b;
	logic signed [SUM_W-1:0]  rnd_x, rnd_y;
	logic signed [ASUM_W-1:0] sum_x, sum_y;
	logic signed [POSE_W-1:0] sat_x, sat_y;

	cordic_req_t creq;
	cordic_res_t cres;

	opi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.res    (cres)
	);

	assign step_stall = (state_q != S_IDLE);
	assign step_acc   = step_valid && !step_stall;
	assign load_ok    = !pose_valid_q || !pose_stall;

	// heading step with a single turn of correction
	always_comb begin
		h_sum = HW'(acc_h_q) + HW'(dh_q);
		if (h_sum > FULL_H)
			h_wrap = h_sum - FULL_H;
		else if (h_sum < -FULL_H)
			h_wrap = h_sum + FULL_H;
		else
			h_wrap = h_sum;
		h_ext = HW'(acc_h_q);
	end

	// fold into plus or minus a quarter turn for the rotation
	always_comb begin
		fold_neg = 1'b1;
		if (ang_q > QUARTER_H)
			fold_ang = ang_q - HALF_H;
		else if (ang_q < -QUARTER_H)
			fold_ang = ang_q + HALF_H;
		else begin
			fold_ang = ang_q;
			fold_neg = 1'b0;
		end
		creq.start = (state_q == S_FOLD);
		creq.neg   = fold_neg;
		creq.z     = ANG_W'(fold_ang) <<< ANG_SHIFT;
	end

	always_comb begin
		unique case (state_q)
			S_MUL0: begin
				mul_a = dx_q;
				mul_b = cres.cos_v;
			end
			S_MUL1: begin
				mul_a = dy_q;
				mul_b = cres.sin_v;
			end
			S_MUL2: begin
				mul_a = dx_q;
				mul_b = cres.sin_v;
			end
			default: begin
				mul_a = dy_q;
				mul_b = cres.cos_v;
			end
		endcase
	end

	always_comb begin
		rnd_x = sx_q + ROUND_BIAS;
		rnd_y = sy_q + ROUND_BIAS;
		sum_x = ASUM_W'(acc_x_q) + ASUM_W'(rx_q);
		sum_y = ASUM_W'(acc_y_q) + ASUM_W'(ry_q);
		if (sum_x[ASUM_W-1] != sum_x[ASUM_W-2])
			sat_x = sum_x[ASUM_W-1] ? ACC_MIN : ACC_MAX;
		else
			sat_x = sum_x[POSE_W-1:0];
		if (sum_y[ASUM_W-1] != sum_y[ASUM_W-2])
			sat_y = sum_y[ASUM_W-1] ? ACC_MIN : ACC_MAX;
		else
			sat_y = sum_y[POSE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pose_valid_q <= 1'b0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_h_q      <= '0;
		end else begin
			if (state_q == S_ACC && load_ok)
				pose_valid_q <= 1'b1;
			else if (!pose_stall)
				pose_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (step_acc) begin
						if (clear_pose) begin
							acc_x_q <= '0;
							acc_y_q <= '0;
							acc_h_q <= '0;
						end
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					acc_h_q <= h_wrap[HACC_W-1:0];
					state_q <= S_MOD;
				end
				S_MOD:    state_q <= S_HALF;
				S_HALF:   state_q <= S_FOLD;
				S_FOLD:   state_q <= S_CORDIC;
				S_CORDIC: if (cres.done) state_q <= S_MUL0;
				S_MUL0:   state_q <= S_MUL1;
				S_MUL1:   state_q <= S_MUL2;
				S_MUL2:   state_q <= S_MUL3;
				S_MUL3:   state_q <= S_MUL4;
				S_MUL4:   state_q <= S_RND;
				S_RND:    state_q <= S_ACC;
				S_ACC: begin
					if (load_ok) begin
						acc_x_q <= sat_x;
						acc_y_q <= sat_y;
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_acc) begin
			dx_q <= step_x;
			dy_q <= step_y;
			dh_q <= step_heading;
		end

		// reduce the stored heading to [0, 360), then to (-180, 180]
		if (state_q == S_MOD) begin
			if (h_ext >= FULL_H)
				ang_q <= h_ext - FULL_H;
			else if (h_ext < 0)
				ang_q <= h_ext + FULL_H;
			else
				ang_q <= h_ext;
		end else if (state_q == S_HALF) begin
			if (ang_q > HALF_H)
				ang_q <= ang_q - FULL_H;
		end

		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);

		case (state_q)
			S_MUL1:  sx_q <= SUM_W'(prod_q);
			S_MUL2:  sx_q <= sx_q - SUM_W'(prod_q);
			S_MUL3:  sy_q <= SUM_W'(prod_q);
			S_MUL4:  sy_q <= sy_q + SUM_W'(prod_q);
			default: ;
		endcase

		if (state_q == S_RND) begin
			rx_q <= rnd_x[SUM_W-1:ROUND_SH];
			ry_q <= rnd_y[SUM_W-1:ROUND_SH];
		end

		if (state_q == S_ACC && load_ok) begin
			pose_x_q <= sat_x;
			pose_y_q <= sat_y;
			pose_h_q <= acc_h_q[PH_W-1:0];
		end
	end

	assign pose_valid   = pose_valid_q;
	assign pose_x       = pose_x_q;
	assign pose_y       = pose_y_q;
	assign pose_heading = pose_h_q;

endmodule

// ===== hdl/opi_checker.sv =====
`include "assert_macros.svh"

module opi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               step_valid,
	input logic                               step_stall,
	input logic                               pose_valid,
	input logic                               pose_stall,
	input logic signed [opi_pkg::POSE_W-1:0]  pose_x,
	input logic signed [opi_pkg::POSE_W-1:0]  pose_y,
	input logic signed [opi_pkg::PH_W-1:0]    pose_heading
);
	import opi_pkg::*;

	// the block is busy straight after taking a step
	`ASSERT_NEXT(a_busy_after_step, clk, arst_n, step_valid && !step_stall, step_stall)

	// a new pose only appears at the end of a step in progress
	`ASSERT_IMPLIES(a_pose_from_work, clk, arst_n, $rose(pose_valid), $past(step_stall))

	// a stalled pose transaction holds its value
	`ASSERT_NEXT(a_pose_hold, clk, arst_n, pose_valid && pose_stall, pose_valid && $stable(pose_x) && $stable(pose_y) && $stable(pose_heading))

endmodule

bind odometry_pose_integrator_top opi_checker u_opi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.step_valid   (step_valid),
	.step_stall   (step_stall),
	.pose_valid   (pose_valid),
	.pose_stall   (pose_stall),
	.pose_x       (pose_x),
	.pose_y       (pose_y),
	.pose_heading (pose_heading)
);
